// ===== rtl/core/sdwr_pkg.sv =====
// Shared types, codes and constants for the steepest-descent water routing unit.
package sdwr_pkg;

    localparam int MAX_CELLS_DEF     = 1024;
    localparam int MAX_NEIGHBORS_DEF = 8;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int NB_W   = 10;
    localparam int CNT_W  = 4;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [10:0] RST_CELLS_IN_USE = 11'd1024;
    localparam logic [15:0] RST_RAIN_RATE    = 16'd328;
    localparam logic [31:0] RST_OCEAN_LEVEL  = 32'd13107;
    localparam logic [31:0] RST_MIN_WATER    = 32'd7;
    localparam logic [16:0] RST_MAX_FRACTION = 17'd52429;
    localparam logic [15:0] RST_SLOPE_GAIN   = 16'd1280;
    localparam logic [16:0] RST_EVAP_KEEP    = 17'd64881;

    typedef enum logic [1:0] {
        CMD_LOAD_CELL = 2'd0,
        CMD_LOAD_NB   = 2'd1,
        CMD_RUN_TICK  = 2'd2,
        CMD_READ_CELL = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_CELLS_IN_USE = 3'd0,
        REG_RAIN_RATE    = 3'd1,
        REG_OCEAN_LEVEL  = 3'd2,
        REG_MIN_WATER    = 3'd3,
        REG_MAX_FRACTION = 3'd4,
        REG_SLOPE_GAIN   = 3'd5,
        REG_EVAP_KEEP    = 3'd6
    } t_reg;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_TCLR,
        ST_CRD,
        ST_CRAIN,
        ST_CSUM,
        ST_WALK,
        ST_SLOPE,
        ST_SHARE,
        ST_SPLIT,
        ST_SELF_RD,
        ST_SELF_WR,
        ST_LOW_RD,
        ST_LOW_WR,
        ST_EVAP_RD,
        ST_EVAP_MUL,
        ST_EVAP_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]       command;
        logic [9:0]       cell_req;
        logic [2:0]       slot;
        logic [31:0]      height;
        logic [31:0]      moisture;
        logic [31:0]      water;
        logic [CNT_W-1:0] neighbor_count;
        logic [NB_W-1:0]  neighbor;
    } t_in_word;

    typedef struct packed {
        logic [31:0] water_out;
        logic        tick_done;
        logic        saturated;
    } t_out_word;

endpackage

// ===== rtl/core/steepest_descent_water_routing_unit.sv =====
// Top level: cell stores, double-banked water memory and tick sequencer.
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    sdwr_pkg::t_in_word
//  out       output     o_out_valid / i_out_ready  sdwr_pkg::t_out_word
//  config    input      APB psel/penable/pwrite    pwdata -> register paddr[4:2]
//
// Load cell / load neighbor: the stores are written as the word is taken. Read cell: an extra ST_READ state
// waits for the registered water memory read. Run tick: the work per active cell is set by the single read port
//   of the water memory (clear, read-modify-write of two entries, evaporation pass) and
//   one height read per neighbor.
// Reset: a clearing pass zeroes every entry of both water banks and the neighbor
//   counts; no word is taken meanwhile, config writes are.
// Stalls: one word in work at a time; a finished result waits in the output
//   register, the next word is taken while it waits.
module steepest_descent_water_routing_unit #(
    parameter int MAX_CELLS     = sdwr_pkg::MAX_CELLS_DEF,
    parameter int MAX_NEIGHBORS = sdwr_pkg::MAX_NEIGHBORS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  sdwr_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output sdwr_pkg::t_out_word         o_out_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdwr_pkg::ADDR_W-1:0] paddr,
    input  logic [sdwr_pkg::DATA_W-1:0] pwdata,
    output logic [sdwr_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;   // cell index
    localparam int NW = CW + 1;                                   // cell count
    localparam int WW = $clog2(2 * MAX_CELLS);                    // water address
    localparam int TW = $clog2(MAX_CELLS * MAX_NEIGHBORS);        // table address
    localparam int NBW = sdwr_pkg::NB_W;
    localparam int KW  = sdwr_pkg::CNT_W;

    // ---------------- configuration registers ----------------
    logic [10:0] r_cells;
    logic [15:0] r_rain;
    logic [31:0] r_ocean_lvl;
    logic [31:0] r_min_w;
    logic [16:0] r_maxf;
    logic [15:0] r_gain;
    logic [16:0] r_keep;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells     <= sdwr_pkg::RST_CELLS_IN_USE;
            r_rain      <= sdwr_pkg::RST_RAIN_RATE;
            r_ocean_lvl <= sdwr_pkg::RST_OCEAN_LEVEL;
            r_min_w     <= sdwr_pkg::RST_MIN_WATER;
            r_maxf      <= sdwr_pkg::RST_MAX_FRACTION;
            r_gain      <= sdwr_pkg::RST_SLOPE_GAIN;
            r_keep      <= sdwr_pkg::RST_EVAP_KEEP;
        end else if (cfg_we) begin
            case (sdwr_pkg::t_reg'(paddr[sdwr_pkg::ADDR_W-1:2]))
                sdwr_pkg::REG_CELLS_IN_USE: r_cells     <= pwdata[10:0];
                sdwr_pkg::REG_RAIN_RATE:    r_rain      <= pwdata[15:0];
                sdwr_pkg::REG_OCEAN_LEVEL:  r_ocean_lvl <= pwdata;
                sdwr_pkg::REG_MIN_WATER:    r_min_w     <= pwdata;
                sdwr_pkg::REG_MAX_FRACTION: r_maxf      <= pwdata[16:0];
                sdwr_pkg::REG_SLOPE_GAIN:   r_gain      <= pwdata[15:0];
                sdwr_pkg::REG_EVAP_KEEP:    r_keep      <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sdwr_pkg::t_reg'(paddr[sdwr_pkg::ADDR_W-1:2]))
            sdwr_pkg::REG_CELLS_IN_USE: prdata = {21'd0, r_cells};
            sdwr_pkg::REG_RAIN_RATE:    prdata = {16'd0, r_rain};
            sdwr_pkg::REG_OCEAN_LEVEL:  prdata = r_ocean_lvl;
            sdwr_pkg::REG_MIN_WATER:    prdata = r_min_w;
            sdwr_pkg::REG_MAX_FRACTION: prdata = {15'd0, r_maxf};
            sdwr_pkg::REG_SLOPE_GAIN:   prdata = {16'd0, r_gain};
            sdwr_pkg::REG_EVAP_KEEP:    prdata = {15'd0, r_keep};
            default:                    prdata = '0;
        endcase
    end

    // fractions above one act as one
    logic [16:0] maxf_c;
    logic [16:0] keep_c;
    assign maxf_c = (r_maxf > sdwr_pkg::ONE_Q16) ? sdwr_pkg::ONE_Q16 : r_maxf;
    assign keep_c = (r_keep > sdwr_pkg::ONE_Q16) ? sdwr_pkg::ONE_Q16 : r_keep;

    // ---------------- memories ----------------
    logic [31:0]    hgt_mem [MAX_CELLS];
    logic [31:0]    mst_mem [MAX_CELLS];
    logic [31:0]    wat_mem [2*MAX_CELLS];
    logic [NBW-1:0] tbl_mem [MAX_CELLS*MAX_NEIGHBORS];
    logic [KW-1:0]  cnt_mem [MAX_CELLS];

    logic           ld_we;
    logic [CW-1:0]  ld_wa;
    logic [CW-1:0]  hgt_ra;
    logic [CW-1:0]  mst_ra;
    logic [31:0]    r_hgt_q;
    logic [31:0]    r_mst_q;
    logic           wat_we;
    logic [WW-1:0]  wat_wa;
    logic [31:0]    wat_wd;
    logic [WW-1:0]  wat_ra;
    logic [31:0]    r_wat_q;
    logic           tbl_we;
    logic [TW-1:0]  tbl_wa;
    logic [TW-1:0]  tbl_ra;
    logic [NBW-1:0] r_tbl_q;
    logic           cnt_we;
    logic [CW-1:0]  cnt_wa;
    logic [KW-1:0]  cnt_wd;
    logic [CW-1:0]  cnt_ra;
    logic [KW-1:0]  r_cnt_q;

    always_ff @(posedge i_clk) begin
        if (ld_we) begin
            hgt_mem[ld_wa] <= i_in_word.height;
            mst_mem[ld_wa] <= i_in_word.moisture;
        end
        r_hgt_q <= hgt_mem[hgt_ra];
        r_mst_q <= mst_mem[mst_ra];
    end

    always_ff @(posedge i_clk) begin
        if (wat_we) wat_mem[wat_wa] <= wat_wd;
        r_wat_q <= wat_mem[wat_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) tbl_mem[tbl_wa] <= i_in_word.neighbor;
        r_tbl_q <= tbl_mem[tbl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
        r_cnt_q <= cnt_mem[cnt_ra];
    end

    function automatic logic [WW-1:0] wat_addr(input logic bank, input logic [CW-1:0] idx);
        return bank ? (WW'(MAX_CELLS) + WW'(idx)) : WW'(idx);
    endfunction

    // ---------------- sequencer state ----------------
    sdwr_pkg::t_state    r_state, n_state;
    logic [WW-1:0]       r_clr, n_clr;
    logic                r_bank, n_bank;
    logic [NW-1:0]       r_i, n_i;
    logic [NW-1:0]       r_n, n_n;
    logic                r_sat, n_sat;
    logic                r_req_ok, n_req_ok;
    logic [31:0]         r_h, n_h;
    logic [31:0]         r_w, n_w;
    logic [KW-1:0]       r_cnt, n_cnt;
    logic                r_ocean, n_ocean;
    logic [48:0]         r_prod, n_prod;
    logic [31:0]         r_c, n_c;
    logic [31:0]         r_low_h, n_low_h;
    logic [CW-1:0]       r_low_idx, n_low_idx;
    logic                r_found, n_found;
    logic [KW-1:0]       r_k, n_k;
    logic                r_v1, n_v1;
    logic                r_v2, n_v2;
    logic [CW-1:0]       r_nb2, n_nb2;
    logic [16:0]         r_share, n_share;
    sdwr_pkg::t_out_word r_res, n_res;
    sdwr_pkg::t_out_word r_out;
    logic                r_ovalid;
    logic                out_load;

    // one multiplier per product, each result registered into r_prod
    logic [31:0] slope_diff;
    logic [47:0] mul_rain;
    logic [47:0] mul_slope;
    logic [48:0] mul_split;
    logic [48:0] mul_keep;
    assign slope_diff = r_h - r_low_h;
    assign mul_rain   = r_mst_q * r_rain;
    assign mul_slope  = slope_diff * r_gain;
    assign mul_split  = r_c * r_share;
    assign mul_keep   = r_wat_q * keep_c;

    logic [31:0] add_a, add_b;
    logic [32:0] sum33;
    logic [31:0] sum_sat;
    logic        cell_end;
    logic [CW-1:0] idx;
    logic        req_ok;

    // saturating adder operands, picked from registered state only
    always_comb begin
        add_a = '0;
        add_b = '0;
        case (r_state)
            sdwr_pkg::ST_CSUM: begin
                add_a = r_w;
                add_b = r_ocean ? 32'd0 : r_prod[47:16];
            end
            sdwr_pkg::ST_SELF_WR: begin
                add_a = r_wat_q;
                add_b = r_found ? (r_c - r_prod[47:16]) : r_c;
            end
            sdwr_pkg::ST_LOW_WR: begin
                add_a = r_wat_q;
                add_b = r_prod[47:16];
            end
            default: ;
        endcase
    end

    assign sum33   = {1'b0, add_a} + {1'b0, add_b};
    assign sum_sat = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];

    assign idx    = r_i[CW-1:0];
    assign req_ok = 32'(i_in_word.cell_req) < 32'(MAX_CELLS);

    assign o_in_ready  = (r_state == sdwr_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sdwr_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_bank   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_bank  <= n_bank;
            if (out_load)
                r_ovalid <= 1'b1;
            else if (i_out_ready)
                r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_n       <= n_n;
        r_sat     <= n_sat;
        r_req_ok  <= n_req_ok;
        r_h       <= n_h;
        r_w       <= n_w;
        r_cnt     <= n_cnt;
        r_ocean   <= n_ocean;
        r_prod    <= n_prod;
        r_c       <= n_c;
        r_low_h   <= n_low_h;
        r_low_idx <= n_low_idx;
        r_found   <= n_found;
        r_k       <= n_k;
        r_v1      <= n_v1;
        r_v2      <= n_v2;
        r_nb2     <= n_nb2;
        r_share   <= n_share;
        r_res     <= n_res;
        if (out_load) r_out <= r_res;
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_bank    = r_bank;
        n_i       = r_i;
        n_n       = r_n;
        n_sat     = r_sat;
        n_req_ok  = r_req_ok;
        n_h       = r_h;
        n_w       = r_w;
        n_cnt     = r_cnt;
        n_ocean   = r_ocean;
        n_prod    = r_prod;
        n_c       = r_c;
        n_low_h   = r_low_h;
        n_low_idx = r_low_idx;
        n_found   = r_found;
        n_k       = r_k;
        n_v1      = r_v1;
        n_v2      = r_v2;
        n_nb2     = r_nb2;
        n_share   = r_share;
        n_res     = r_res;
        out_load  = 1'b0;
        cell_end  = 1'b0;

        ld_we  = 1'b0;
        ld_wa  = CW'(i_in_word.cell_req);
        hgt_ra = idx;
        mst_ra = idx;
        wat_we = 1'b0;
        wat_wa = wat_addr(~r_bank, idx);
        wat_wd = '0;
        wat_ra = wat_addr(~r_bank, idx);
        tbl_we = 1'b0;
        tbl_wa = TW'(32'(i_in_word.cell_req) * 32'(MAX_NEIGHBORS) + 32'(i_in_word.slot));
        tbl_ra = TW'(32'(idx) * 32'(MAX_NEIGHBORS) + 32'(r_k));
        cnt_we = 1'b0;
        cnt_wa = CW'(i_in_word.cell_req);
        cnt_wd = '0;
        cnt_ra = idx;

        case (r_state)
            sdwr_pkg::ST_CLEAR: begin
                wat_we = 1'b1;
                wat_wa = r_clr;
                if (32'(r_clr) < 32'(MAX_CELLS)) begin
                    cnt_we = 1'b1;
                    cnt_wa = CW'(r_clr);
                end
                n_clr = r_clr + WW'(1);
                if (r_clr == WW'(2*MAX_CELLS-1)) n_state = sdwr_pkg::ST_IDLE;
            end

            sdwr_pkg::ST_IDLE: begin
                wat_ra = wat_addr(r_bank, CW'(i_in_word.cell_req));
                if (i_in_valid) begin
                    n_res = '0;
                    n_state = sdwr_pkg::ST_DONE;
                    case (sdwr_pkg::t_cmd'(i_in_word.command))
                        sdwr_pkg::CMD_LOAD_CELL: begin
                            if (req_ok) begin
                                ld_we  = 1'b1;
                                wat_we = 1'b1;
                                wat_wa = wat_addr(r_bank, CW'(i_in_word.cell_req));
                                wat_wd = i_in_word.water;
                                cnt_we = 1'b1;
                                cnt_wd = (32'(i_in_word.neighbor_count) > 32'(MAX_NEIGHBORS))
                                         ? KW'(MAX_NEIGHBORS) : i_in_word.neighbor_count;
                            end
                        end
                        sdwr_pkg::CMD_LOAD_NB: begin
                            if (req_ok && (32'(i_in_word.slot) < 32'(MAX_NEIGHBORS)))
                                tbl_we = 1'b1;
                        end
                        sdwr_pkg::CMD_RUN_TICK: begin
                            n_n   = (32'(r_cells) > 32'(MAX_CELLS)) ? NW'(MAX_CELLS)
                                                                     : NW'(r_cells);
                            n_i   = '0;
                            n_sat = 1'b0;
                            if (n_n == '0) begin
                                n_bank = ~r_bank;
                                n_res.tick_done = 1'b1;
                            end else begin
                                n_state = sdwr_pkg::ST_TCLR;
                            end
                        end
                        sdwr_pkg::CMD_READ_CELL: begin
                            n_req_ok = req_ok;
                            n_state  = sdwr_pkg::ST_READ;
                        end
                        default: ;
                    endcase
                end
            end

            sdwr_pkg::ST_READ: begin
                n_res = '0;
                if (r_req_ok) n_res.water_out = r_wat_q;
                n_state = sdwr_pkg::ST_DONE;
            end

            // zero next-bank entries of the active cells
            sdwr_pkg::ST_TCLR: begin
                wat_we = 1'b1;
                if ((r_i + NW'(1)) < r_n) begin
                    n_i = r_i + NW'(1);
                end else begin
                    n_i = '0;
                    n_state = sdwr_pkg::ST_CRD;
                end
            end

            sdwr_pkg::ST_CRD: begin
                wat_ra  = wat_addr(r_bank, idx);
                n_state = sdwr_pkg::ST_CRAIN;
            end

            sdwr_pkg::ST_CRAIN: begin
                n_h     = r_hgt_q;
                n_w     = r_wat_q;
                n_cnt   = r_cnt_q;
                n_ocean = r_hgt_q < r_ocean_lvl;
                n_prod  = 49'(mul_rain);
                n_state = sdwr_pkg::ST_CSUM;
            end

            sdwr_pkg::ST_CSUM: begin
                if (sum33[32]) n_sat = 1'b1;
                n_c = sum_sat;
                if (sum_sat < r_min_w) begin
                    cell_end = 1'b1;
                end else if (r_ocean) begin
                    wat_we   = 1'b1;           // also drops water moved in earlier
                    cell_end = 1'b1;
                end else begin
                    n_k     = '0;
                    n_v1    = 1'b0;
                    n_v2    = 1'b0;
                    n_low_h = r_h;
                    n_found = 1'b0;
                    n_state = sdwr_pkg::ST_WALK;
                end
            end

            // slot read -> height read -> compare, one neighbor per cycle
            sdwr_pkg::ST_WALK: begin
                if (r_k < r_cnt) begin
                    n_v1 = 1'b1;
                    n_k  = r_k + KW'(1);
                end else begin
                    n_v1 = 1'b0;
                end
                n_v2 = 1'b0;
                if (r_v1 && (32'(r_tbl_q) < 32'(MAX_CELLS))) begin
                    hgt_ra = CW'(r_tbl_q);
                    n_v2   = 1'b1;
                    n_nb2  = CW'(r_tbl_q);
                end
                if (r_v2 && (r_hgt_q < r_low_h)) begin
                    n_low_h   = r_hgt_q;
                    n_low_idx = r_nb2;
                    n_found   = 1'b1;
                end
                if ((r_k == r_cnt) && !r_v1 && !r_v2)
                    n_state = r_found ? sdwr_pkg::ST_SLOPE : sdwr_pkg::ST_SELF_RD;
            end

            sdwr_pkg::ST_SLOPE: begin
                n_prod  = 49'(mul_slope);
                n_state = sdwr_pkg::ST_SHARE;
            end

            sdwr_pkg::ST_SHARE: begin
                n_share = (r_prod[48:8] > 41'(maxf_c)) ? maxf_c : r_prod[24:8];
                n_state = sdwr_pkg::ST_SPLIT;
            end

            sdwr_pkg::ST_SPLIT: begin
                n_prod  = mul_split;
                n_state = sdwr_pkg::ST_SELF_RD;
            end

            sdwr_pkg::ST_SELF_RD: begin
                n_state = sdwr_pkg::ST_SELF_WR;
            end

            sdwr_pkg::ST_SELF_WR: begin
                wat_we = 1'b1;
                wat_wd = sum_sat;
                if (sum33[32]) n_sat = 1'b1;
                if (r_found) n_state = sdwr_pkg::ST_LOW_RD;
                else         cell_end = 1'b1;
            end

            sdwr_pkg::ST_LOW_RD: begin
                wat_ra  = wat_addr(~r_bank, r_low_idx);
                n_state = sdwr_pkg::ST_LOW_WR;
            end

            sdwr_pkg::ST_LOW_WR: begin
                wat_we = 1'b1;
                wat_wa = wat_addr(~r_bank, r_low_idx);
                wat_wd = sum_sat;
                if (sum33[32]) n_sat = 1'b1;
                cell_end = 1'b1;
            end

            sdwr_pkg::ST_EVAP_RD: begin
                n_state = sdwr_pkg::ST_EVAP_MUL;
            end

            sdwr_pkg::ST_EVAP_MUL: begin
                n_prod  = mul_keep;
                n_state = sdwr_pkg::ST_EVAP_WR;
            end

            sdwr_pkg::ST_EVAP_WR: begin
                wat_we = 1'b1;
                wat_wd = r_prod[47:16];
                if ((r_i + NW'(1)) < r_n) begin
                    n_i     = r_i + NW'(1);
                    n_state = sdwr_pkg::ST_EVAP_RD;
                end else begin
                    n_bank          = ~r_bank;
                    n_res           = '0;
                    n_res.tick_done = 1'b1;
                    n_res.saturated = r_sat;
                    n_state         = sdwr_pkg::ST_DONE;
                end
            end

            sdwr_pkg::ST_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = sdwr_pkg::ST_IDLE;
                end
            end

            default: n_state = sdwr_pkg::ST_IDLE;
        endcase

        // advance to the next cell, or on to the evaporation pass
        if (cell_end) begin
            if ((r_i + NW'(1)) < r_n) begin
                n_i     = r_i + NW'(1);
                n_state = sdwr_pkg::ST_CRD;
            end else begin
                n_i     = '0;
                n_state = sdwr_pkg::ST_EVAP_RD;
            end
        end
    end

endmodule

// ===== rtl/core/sdwr_checker.sv =====
// Port-level checker for the water routing unit and its bind.
module sdwr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input sdwr_pkg::t_out_word o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("took a second word while one is in work");

    a_tick_no_water: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.tick_done |-> o_out_word.water_out == 32'd0)
        else $error("tick result carries water");

    a_sat_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.saturated |-> o_out_word.tick_done)
        else $error("saturated flag outside a tick result");

endmodule

bind steepest_descent_water_routing_unit sdwr_checker u_sdwr_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the steepest-descent water routing unit.
module tb_top;

    localparam int NCELL     = 1024;
    localparam int NSLOT     = 8;
    localparam int WORK_SPAN = 16;        // cells used by most random traffic
    localparam int CYC_LIMIT = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // input channel
    logic                in_valid = 1'b0;
    logic                in_ready;
    sdwr_pkg::t_in_word  in_word = '0;

    // output channel
    logic                out_valid;
    logic                out_ready = 1'b0;
    sdwr_pkg::t_out_word out_word;

    // config port
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    steepest_descent_water_routing_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: mirror of the block's stores and registers.
    // ------------------------------------------------------------------
    logic [31:0] height_m  [0:NCELL-1];
    logic [31:0] moist_m   [0:NCELL-1];
    logic [31:0] water_m   [0:2*NCELL-1];
    logic [9:0]  nb_m      [0:NCELL*NSLOT-1];
    logic [3:0]  nb_cnt_m  [0:NCELL-1];
    logic        bank_m = 1'b0;
    logic        sat_seen;

    logic [10:0] cfg_cells = sdwr_pkg::RST_CELLS_IN_USE;
    logic [15:0] cfg_rain  = sdwr_pkg::RST_RAIN_RATE;
    logic [31:0] cfg_ocean = sdwr_pkg::RST_OCEAN_LEVEL;
    logic [31:0] cfg_minw  = sdwr_pkg::RST_MIN_WATER;
    logic [16:0] cfg_maxf  = sdwr_pkg::RST_MAX_FRACTION;
    logic [15:0] cfg_slope = sdwr_pkg::RST_SLOPE_GAIN;
    logic [16:0] cfg_keep  = sdwr_pkg::RST_EVAP_KEEP;

    // Stimulus bookkeeping: which cells and slots have been written, so that
    // no tick ever looks at an unwritten height, moisture or neighbor slot.
    bit       cell_loaded [0:NCELL-1];
    bit [7:0] slot_written[0:NCELL-1];

    sdwr_pkg::t_in_word  pend_q[$];      // words waiting to be driven
    sdwr_pkg::t_out_word water_exp_q[$]; // expected results, oldest first

    int errors     = 0;
    int n_words    = 0;
    int n_ticks    = 0;
    int n_sat      = 0;
    int n_results  = 0;
    int cyc        = 0;

    initial begin
        for (int i = 0; i < 2*NCELL; i++) water_m[i] = '0;
        for (int i = 0; i < NCELL; i++) begin
            nb_cnt_m[i]     = '0;
            height_m[i]     = '0;
            moist_m[i]      = '0;
            cell_loaded[i]  = 1'b0;
            slot_written[i] = '0;
        end
        for (int i = 0; i < NCELL*NSLOT; i++) nb_m[i] = '0;
    end

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[32]) begin
            sat_seen = 1'b1;
            return '1;
        end
        return s[31:0];
    endfunction

    // One routing tick over the active cells, then bank swap.
    task automatic route_tick();
        int          n, cur, nxt, cnt, low_idx;
        logic [31:0] h, rain, c, low_h, t, nbh;
        logic [63:0] share;
        logic [16:0] maxf, keep;
        bit          ocean, found;
        n    = (cfg_cells > NCELL) ? NCELL : int'(cfg_cells);
        cur  = bank_m ? NCELL : 0;
        nxt  = bank_m ? 0 : NCELL;
        maxf = (cfg_maxf > sdwr_pkg::ONE_Q16) ? sdwr_pkg::ONE_Q16 : cfg_maxf;
        keep = (cfg_keep > sdwr_pkg::ONE_Q16) ? sdwr_pkg::ONE_Q16 : cfg_keep;
        for (int i = 0; i < n; i++) water_m[nxt+i] = '0;
        for (int i = 0; i < n; i++) begin
            h     = height_m[i];
            ocean = h < cfg_ocean;
            rain  = ocean ? 32'd0 : 32'((64'(moist_m[i]) * 64'(cfg_rain)) >> 16);
            c     = sat_add(water_m[cur+i], rain);
            if (c < cfg_minw) continue;
            if (ocean) begin
                water_m[nxt+i] = '0;
                continue;
            end
            cnt     = (nb_cnt_m[i] > NSLOT) ? NSLOT : int'(nb_cnt_m[i]);
            low_h   = h;
            low_idx = 0;
            found   = 1'b0;
            // strictly lower only, so the first slot keeps a tie
            for (int k = 0; k < cnt; k++) begin
                nbh = height_m[nb_m[i*NSLOT+k]];
                if (nbh < low_h) begin
                    low_h   = nbh;
                    low_idx = int'(nb_m[i*NSLOT+k]);
                    found   = 1'b1;
                end
            end
            if (found) begin
                share = (64'(h - low_h) * 64'(cfg_slope)) >> 8;
                if (share > 64'(maxf)) share = 64'(maxf);
                t = 32'((64'(c) * share) >> 16);
                water_m[nxt+i]       = sat_add(water_m[nxt+i], c - t);
                water_m[nxt+low_idx] = sat_add(water_m[nxt+low_idx], t);
            end else begin
                water_m[nxt+i] = sat_add(water_m[nxt+i], c);
            end
        end
        for (int i = 0; i < n; i++)
            water_m[nxt+i] = 32'((64'(water_m[nxt+i]) * 64'(keep)) >> 16);
        bank_m = ~bank_m;
    endtask

    // Applies one accepted word to the mirror and queues its result.
    task automatic apply_word(input sdwr_pkg::t_in_word w);
        sdwr_pkg::t_out_word r;
        int                  cur;
        r   = '0;
        cur = bank_m ? NCELL : 0;
        case (sdwr_pkg::t_cmd'(w.command))
            sdwr_pkg::CMD_LOAD_CELL: begin
                height_m[w.cell_req]    = w.height;
                moist_m[w.cell_req]     = w.moisture;
                water_m[cur+w.cell_req] = w.water;
                nb_cnt_m[w.cell_req]    = (w.neighbor_count > NSLOT) ? 4'(NSLOT)
                                                                   : w.neighbor_count;
            end
            sdwr_pkg::CMD_LOAD_NB:
                nb_m[w.cell_req*NSLOT + w.slot] = w.neighbor;
            sdwr_pkg::CMD_RUN_TICK: begin
                sat_seen = 1'b0;
                route_tick();
                r.tick_done = 1'b1;
                r.saturated = sat_seen;
                n_ticks++;
                if (sat_seen) n_sat++;
            end
            default:
                r.water_out = water_m[cur+w.cell_req];
        endcase
        water_exp_q.push_back(r);
        n_words++;
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length with random gaps.
    // ------------------------------------------------------------------
    int burst_left = 4;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) apply_word(in_word);
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    in_word  <= pend_q.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: the receiver stall pattern steps through three modes picked from the
    // cycle counter (always ready, random stalls, periodic stall).
    // ------------------------------------------------------------------
    task automatic report(input string what, input logic [31:0] exp_v,
                          input logic [31:0] got_v);
        errors++;
        $display("[%0t] mismatch %s: expected %h got %h", $time, what, exp_v, got_v);
    endtask

    always @(posedge i_clk) begin
        sdwr_pkg::t_out_word e;
        cyc <= cyc + 1;
        case ((cyc >> 9) % 3)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= (cyc[2:0] != 3'd0) && (cyc[2:0] != 3'd1);
        endcase
        if (i_rst_n && out_valid && out_ready) begin
            n_results++;
            if (water_exp_q.size() == 0) begin
                report("unexpected word", 32'd0, out_word.water_out);
            end else begin
                e = water_exp_q.pop_front();
                if (out_word.water_out !== e.water_out)
                    report("water_out", e.water_out, out_word.water_out);
                if (out_word.tick_done !== e.tick_done)
                    report("tick_done", 32'(e.tick_done), 32'(out_word.tick_done));
                if (out_word.saturated !== e.saturated)
                    report("saturated", 32'(e.saturated), 32'(out_word.saturated));
            end
        end
    end

    always @(posedge i_clk) begin
        if (cyc > CYC_LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending", cyc, water_exp_q.size());
            $display("** steepest_descent_water_routing_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic sdwr_pkg::t_in_word noise_word(input sdwr_pkg::t_cmd cmd);
        sdwr_pkg::t_in_word w;
        w = sdwr_pkg::t_in_word'($bits(sdwr_pkg::t_in_word)'({$urandom, $urandom,
                                                              $urandom, $urandom}));
        w.command = cmd;
        return w;
    endfunction

    task automatic add_load(input int c, input logic [31:0] h, input logic [31:0] m,
                            input logic [31:0] wt, input int cnt);
        sdwr_pkg::t_in_word w;
        w = noise_word(sdwr_pkg::CMD_LOAD_CELL);
        w.cell_req = 10'(c);
        w.height = h;
        w.moisture = m;
        w.water = wt;
        w.neighbor_count = 4'(cnt);
        cell_loaded[c] = 1'b1;
        pend_q.push_back(w);
    endtask

    task automatic add_nb(input int c, input int s, input int nb);
        sdwr_pkg::t_in_word w;
        w = noise_word(sdwr_pkg::CMD_LOAD_NB);
        w.cell_req = 10'(c);
        w.slot = 3'(s);
        w.neighbor = 10'(nb);
        slot_written[c][s] = 1'b1;
        pend_q.push_back(w);
    endtask

    task automatic add_simple(input sdwr_pkg::t_cmd cmd, input int c);
        sdwr_pkg::t_in_word w;
        w = noise_word(cmd);
        w.cell_req = 10'(c);
        pend_q.push_back(w);
    endtask

    // neighbor count that only covers written slots; 9..15 clamp to 8
    function automatic int pick_cnt(input int c);
        int ok;
        ok = 0;
        while (ok < NSLOT && slot_written[c][ok]) ok++;
        if (ok == NSLOT) return $urandom_range(0, 15);
        return $urandom_range(0, ok);
    endfunction

    function automatic int pick_nb();
        int nb;
        nb = $urandom_range(0, NCELL-1);
        if (cell_loaded[nb]) return nb;
        return $urandom_range(0, WORK_SPAN-1);
    endfunction

    function automatic bit tick_safe();
        int n;
        n = (cfg_cells > NCELL) ? NCELL : int'(cfg_cells);
        for (int i = 0; i < n; i++)
            if (!cell_loaded[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] pick_height();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 32'h0000_8000);
            default: return 32'h0001_0000 + $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_water();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 32'h0010_0000);
            2:       return $urandom_range(0, 16);
            default: return $urandom_range(0, 32'h0040_0000);
        endcase
    endfunction

    task automatic random_word();
        int r, c;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NCELL-1)
                                            : $urandom_range(0, WORK_SPAN-1);
            add_load(c, pick_height(), $urandom, pick_water(), pick_cnt(c));
        end else if (r < 60) begin
            add_nb($urandom_range(0, WORK_SPAN-1), $urandom_range(0, NSLOT-1), pick_nb());
        end else if (r < 78 && tick_safe()) begin
            add_simple(sdwr_pkg::CMD_RUN_TICK, $urandom_range(0, NCELL-1));
        end else begin
            add_simple(sdwr_pkg::CMD_READ_CELL,
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, NCELL-1)
                                                   : $urandom_range(0, WORK_SPAN-1));
        end
    endtask

    // APB write: setup cycle, then access cycle; pready is always high.
    task automatic reg_write(input sdwr_pkg::t_reg r, input logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            sdwr_pkg::REG_CELLS_IN_USE: cfg_cells = v[10:0];
            sdwr_pkg::REG_RAIN_RATE:    cfg_rain  = v[15:0];
            sdwr_pkg::REG_OCEAN_LEVEL:  cfg_ocean = v;
            sdwr_pkg::REG_MIN_WATER:    cfg_minw  = v;
            sdwr_pkg::REG_MAX_FRACTION: cfg_maxf  = v[16:0];
            sdwr_pkg::REG_SLOPE_GAIN:   cfg_slope = v[15:0];
            sdwr_pkg::REG_EVAP_KEEP:    cfg_keep  = v[16:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [31:0] cells, input logic [31:0] rain,
                           input logic [31:0] ocean, input logic [31:0] minw,
                           input logic [31:0] maxf, input logic [31:0] slope,
                           input logic [31:0] keep);
        reg_write(sdwr_pkg::REG_CELLS_IN_USE, cells);
        reg_write(sdwr_pkg::REG_RAIN_RATE, rain);
        reg_write(sdwr_pkg::REG_OCEAN_LEVEL, ocean);
        reg_write(sdwr_pkg::REG_MIN_WATER, minw);
        reg_write(sdwr_pkg::REG_MAX_FRACTION, maxf);
        reg_write(sdwr_pkg::REG_SLOPE_GAIN, slope);
        reg_write(sdwr_pkg::REG_EVAP_KEEP, keep);
    endtask

    // Sender holds off until every expected word is back, then a short pause.
    task automatic drain();
        while (pend_q.size() != 0 || in_valid || water_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: saturating rain, ocean cell, tie on lowest neighbor,
        // full-share move, a maximum fraction above one, neighbor count above eight.
        set_all(32'd6, 32'h0000_FFFF, 32'h0001_0000, 32'd0, 32'h0001_FFFF,
                32'h0000_FFFF, 32'h0001_0000);
        add_simple(sdwr_pkg::CMD_READ_CELL, 0);
        add_load(0, 32'h0005_0000, 32'hFFFF_FFFF, 32'hFFFF_F000, 3);
        add_load(1, 32'h0002_0000, 0, 32'h0000_1000, 0);
        add_load(2, 32'h0002_0000, 0, 0, 0);
        add_load(3, 32'h0000_0000, 1234, 32'h0000_5000, 0);
        add_load(4, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1);
        for (int s = 0; s < NSLOT; s++) add_nb(5, s, s % 5);
        add_load(5, 32'h0003_0000, 32'h0001_0000, 0, 12);
        add_nb(0, 0, 5);
        add_nb(0, 1, 1);
        add_nb(0, 2, 2);
        add_nb(4, 0, 0);
        add_simple(sdwr_pkg::CMD_RUN_TICK, 0);
        for (int i = 0; i < 6; i++) add_simple(sdwr_pkg::CMD_READ_CELL, i);
        drain();

        // no active cells: only the bank swap happens
        reg_write(sdwr_pkg::REG_CELLS_IN_USE, 32'd0);
        add_simple(sdwr_pkg::CMD_RUN_TICK, 0);
        add_simple(sdwr_pkg::CMD_READ_CELL, 0);
        drain();

        // fill the working span, then random phases with random settings
        for (int i = 6; i < WORK_SPAN; i++)
            add_load(i, pick_height(), $urandom, pick_water(), 0);
        drain();
        for (int p = 0; p < 3; p++) begin
            set_all($urandom_range(1, WORK_SPAN), $urandom_range(0, 16'hFFFF),
                    $urandom_range(0, 32'h0003_0000),
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000),
                    $urandom_range(0, 17'h1FFFF), $urandom_range(0, 16'hFFFF),
                    $urandom_range(17'h8000, 17'h1FFFF));
            for (int k = 0; k < 18; k++) random_word();
            drain();
        end

        // one cell, default-like settings
        set_all(32'd1, 32'(sdwr_pkg::RST_RAIN_RATE), sdwr_pkg::RST_OCEAN_LEVEL,
                sdwr_pkg::RST_MIN_WATER, 32'(sdwr_pkg::RST_MAX_FRACTION),
                32'(sdwr_pkg::RST_SLOPE_GAIN), 32'(sdwr_pkg::RST_EVAP_KEEP));
        for (int k = 0; k < 10; k++) random_word();
        add_simple(sdwr_pkg::CMD_RUN_TICK, 0);
        add_simple(sdwr_pkg::CMD_READ_CELL, 0);
        drain();
        repeat (50) @(posedge i_clk);

        $display("covered %0d words and %0d results, %0d ticks (%0d saturating)",
                 n_words, n_results, n_ticks, n_sat);
        $display("settings included zero and one active cells, clamped fractions and counts");
        if (errors == 0 && water_exp_q.size() == 0) begin
            $display("** steepest_descent_water_routing_unit: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, water_exp_q.size());
            $display("** steepest_descent_water_routing_unit: FAILED **");
        end
        $finish;
    end

endmodule
